[hw/rtl/segchn_pkg.sv]
package segchn_pkg;

  // Widths of the id ports
  localparam int ID_FIELD_W = 16;

  // Default build
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_ID_BITS      = 16;

  // Input command codes
  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_ASSEMBLE = 1'b1;

endpackage

[hw/rtl/segment_chain_assembler.sv]
// Add: accepted in IDLE, scans the stored segments for a duplicate, then stores the pair, no result.
// Assemble: per chain, states FIND, START and SEED start it, one table scan per segment
// joined plus one failing scan, then states ERD and EOUT for each waypoint.
// The segment table is a synchronous RAM with one read and one write port.
// Reset clears the control state, live flags, count and overflow flag; the
// RAM contents are left as they are and need no clearing pass.
module segment_chain_assembler #(
  parameter int MAX_SEGMENTS = segchn_pkg::DEF_MAX_SEGMENTS,
  parameter int ID_BITS      = segchn_pkg::DEF_ID_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [segchn_pkg::ID_FIELD_W-1:0] in_from_id,
  input  logic [segchn_pkg::ID_FIELD_W-1:0] in_to_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [segchn_pkg::ID_FIELD_W-1:0] out_waypoint_id,
  output logic                              out_chain_last,
  output logic                              out_run_last,
  output logic                              out_dropped
);
  import segchn_pkg::*;

  localparam int SW    = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int IW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int BDEP  = 2 * MAX_SEGMENTS + 1;
  localparam int PW    = $clog2(BDEP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_SEED  = 3'd4;
  localparam logic [2:0] ST_GROW  = 3'd5;
  localparam logic [2:0] ST_ERD   = 3'd6;
  localparam logic [2:0] ST_EOUT  = 3'd7;

  // Storage
  logic [2*SW-1:0] seg_mem [MAX_SEGMENTS];
  logic [2*SW-1:0] seg_rd_r;
  logic [SW-1:0]   buf_mem [BDEP];
  logic [SW-1:0]   buf_rd_r;

  // Control
  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    overflow_r, overflow_nxt;
  logic [MAX_SEGMENTS-1:0] live_r, live_nxt;
  logic [CW-1:0]           issue_r, issue_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]           rd_idx_r, rd_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Datapath
  logic [SW-1:0] a_r, a_nxt;
  logic [SW-1:0] b_r, b_nxt;
  logic [SW-1:0] head_val_r, head_val_nxt;
  logic [SW-1:0] tail_val_r, tail_val_nxt;
  logic [PW-1:0] head_ptr_r, head_ptr_nxt;
  logic [PW-1:0] tail_ptr_r, tail_ptr_nxt;
  logic [PW-1:0] emit_ptr_r, emit_ptr_nxt;
  logic [ID_FIELD_W-1:0] out_id_r, out_id_nxt;
  logic out_chain_last_r, out_chain_last_nxt;
  logic out_run_last_r, out_run_last_nxt;
  logic out_dropped_r, out_dropped_nxt;

  // Memory ports
  logic [IW-1:0]   seg_raddr;
  logic            seg_we;
  logic [2*SW-1:0] seg_wdata;
  logic            buf_we;
  logic [PW-1:0]   buf_waddr;
  logic [SW-1:0]   buf_wdata;

  logic [SW-1:0] rd_start, rd_end;
  logic [IW-1:0] first_idx;
  logic          any_live;
  logic          hit_ts, hit_te, hit_hs, hit_he, hit_any, hit_live;
  logic          issue_more, scan_last;
  logic          chain_end;

  assign rd_start = seg_rd_r[2*SW-1:SW];
  assign rd_end   = seg_rd_r[SW-1:0];
  assign any_live = |live_r;

  always_comb begin
    first_idx = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (live_r[i]) first_idx = IW'(i);
    end
  end

  assign hit_live   = rd_vld_r && live_r[rd_idx_r];
  assign hit_ts     = rd_start == tail_val_r;
  assign hit_te     = rd_end   == tail_val_r;
  assign hit_hs     = rd_start == head_val_r;
  assign hit_he     = rd_end   == head_val_r;
  assign hit_any    = hit_live && (hit_ts || hit_te || hit_hs || hit_he);
  assign issue_more = issue_r < CW'(MAX_SEGMENTS);
  assign scan_last  = rd_idx_r == IW'(MAX_SEGMENTS - 1);
  assign chain_end  = emit_ptr_r == tail_ptr_r;

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    overflow_nxt       = overflow_r;
    live_nxt           = live_r;
    issue_nxt          = issue_r;
    rd_vld_nxt         = 1'b0;
    rd_idx_nxt         = issue_r[IW-1:0];
    out_valid_nxt      = out_valid_r;
    a_nxt              = a_r;
    b_nxt              = b_r;
    head_val_nxt       = head_val_r;
    tail_val_nxt       = tail_val_r;
    head_ptr_nxt       = head_ptr_r;
    tail_ptr_nxt       = tail_ptr_r;
    emit_ptr_nxt       = emit_ptr_r;
    out_id_nxt         = out_id_r;
    out_chain_last_nxt = out_chain_last_r;
    out_run_last_nxt   = out_run_last_r;
    out_dropped_nxt    = out_dropped_r;
    seg_raddr          = issue_r[IW-1:0];
    seg_we             = 1'b0;
    seg_wdata          = {a_r, b_r};
    buf_we             = 1'b0;
    buf_waddr          = tail_ptr_r;
    buf_wdata          = tail_val_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        issue_nxt = '0;
        if (in_valid) begin
          if (in_cmd == CMD_ADD) begin
            a_nxt     = in_from_id[SW-1:0];
            b_nxt     = in_to_id[SW-1:0];
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_FIND;
          end
        end
      end

      ST_ADD: begin
        // Scan stored pairs for an exact duplicate
        if (issue_r < count_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end
        if (hit_live && rd_start == a_r && rd_end == b_r) begin
          state_nxt = ST_IDLE;
        end else if (!rd_vld_r && !(issue_r < count_r)) begin
          if (count_r >= CW'(MAX_SEGMENTS)) begin
            overflow_nxt = 1'b1;
          end else begin
            seg_we                       = 1'b1;
            live_nxt[count_r[IW-1:0]]    = 1'b1;
            count_nxt                    = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_FIND: begin
        seg_raddr = first_idx;
        if (any_live) begin
          live_nxt[first_idx] = 1'b0;
          state_nxt           = ST_START;
        end else begin
          count_nxt    = '0;
          overflow_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      ST_START: begin
        head_val_nxt = rd_start;
        tail_val_nxt = rd_end;
        head_ptr_nxt = PW'(MAX_SEGMENTS);
        tail_ptr_nxt = PW'(MAX_SEGMENTS + 1);
        buf_we       = 1'b1;
        buf_waddr    = PW'(MAX_SEGMENTS);
        buf_wdata    = rd_start;
        state_nxt    = ST_SEED;
      end

      ST_SEED: begin
        buf_we    = 1'b1;
        issue_nxt = '0;
        state_nxt = ST_GROW;
      end

      ST_GROW: begin
        if (issue_more) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
        end
        if (hit_any) begin
          // Join at the tail first, then at the head; restart the scan
          live_nxt[rd_idx_r] = 1'b0;
          rd_vld_nxt         = 1'b0;
          issue_nxt          = '0;
          buf_we             = 1'b1;
          if (hit_ts || hit_te) begin
            tail_val_nxt = hit_ts ? rd_end : rd_start;
            tail_ptr_nxt = tail_ptr_r + 1'b1;
            buf_waddr    = tail_ptr_r + 1'b1;
            buf_wdata    = tail_val_nxt;
          end else begin
            head_val_nxt = hit_hs ? rd_end : rd_start;
            head_ptr_nxt = head_ptr_r - 1'b1;
            buf_waddr    = head_ptr_r - 1'b1;
            buf_wdata    = head_val_nxt;
          end
        end else if (rd_vld_r && scan_last) begin
          emit_ptr_nxt = head_ptr_r;
          state_nxt    = ST_ERD;
        end
      end

      ST_ERD: begin
        state_nxt = ST_EOUT;
      end

      ST_EOUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_id_nxt         = ID_FIELD_W'(buf_rd_r);
          out_chain_last_nxt = chain_end;
          out_run_last_nxt   = chain_end && !any_live;
          out_dropped_nxt    = overflow_r;
          if (chain_end) begin
            state_nxt = ST_FIND;
          end else begin
            emit_ptr_nxt = emit_ptr_r + 1'b1;
            state_nxt    = ST_ERD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      live_r      <= '0;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      live_r      <= live_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r         <= rd_idx_nxt;
    a_r              <= a_nxt;
    b_r              <= b_nxt;
    head_val_r       <= head_val_nxt;
    tail_val_r       <= tail_val_nxt;
    head_ptr_r       <= head_ptr_nxt;
    tail_ptr_r       <= tail_ptr_nxt;
    emit_ptr_r       <= emit_ptr_nxt;
    out_id_r         <= out_id_nxt;
    out_chain_last_r <= out_chain_last_nxt;
    out_run_last_r   <= out_run_last_nxt;
    out_dropped_r    <= out_dropped_nxt;
  end

  // Segment table
  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[count_r[IW-1:0]] <= seg_wdata;
    seg_rd_r <= seg_mem[seg_raddr];
  end

  // Chain buffer
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rd_r <= buf_mem[emit_ptr_r];
  end

  assign in_ready        = state_r == ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_waypoint_id = out_id_r;
  assign out_chain_last  = out_chain_last_r;
  assign out_run_last    = out_run_last_r;
  assign out_dropped     = out_dropped_r;

endmodule

[bench/segment_chain_assembler_test.sv]
module segment_chain_assembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import segchn_pkg::*;

  localparam int SEGS        = DEF_MAX_SEGMENTS;
  localparam int PATH_DEPTH  = 2 * DEF_MAX_SEGMENTS + 1;
  localparam int RAND_ITEMS  = 470;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 64;

  typedef logic [ID_FIELD_W-1:0] wp_id_t;

  typedef struct packed {
    logic   cmd;
    wp_id_t from_id;
    wp_id_t to_id;
  } seg_cmd_t;

  typedef struct packed {
    wp_id_t id;
    logic   chain_last;
    logic   run_last;
    logic   dropped;
  } waypoint_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LOOSE, RX_TIGHT, RX_PERIODIC} rx_mode_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_cmd    = CMD_ADD;
  wp_id_t in_from_id = '0;
  wp_id_t in_to_id   = '0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  wp_id_t out_waypoint_id;
  logic   out_chain_last;
  logic   out_run_last;
  logic   out_dropped;

  seg_cmd_t  seg_cmds_q[$];
  waypoint_t route_q[$];

  // Shadow of the segment table and chain buffer
  wp_id_t seg_from [SEGS];
  wp_id_t seg_to   [SEGS];
  bit     seg_live [SEGS];
  int     seg_fill;
  bit     lost_seg;
  wp_id_t path_buf [PATH_DEPTH];
  int     path_head;
  int     path_tail;

  int total_items;
  int items_taken;
  int err_cnt;
  int cycle_cnt;
  int n_assemblies;
  int n_chains;
  int n_waypoints;
  int n_flagged;
  int hold_left;
  bit hold_done;

  segment_chain_assembler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_from_id      (in_from_id),
    .in_to_id        (in_to_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_waypoint_id (out_waypoint_id),
    .out_chain_last  (out_chain_last),
    .out_run_last    (out_run_last),
    .out_dropped     (out_dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void table_insert(wp_id_t a, wp_id_t b);
    int i;
    for (i = 0; i < SEGS; i++)
      if (seg_live[i] && seg_from[i] == a && seg_to[i] == b)
        return;
    if (seg_fill >= SEGS) begin
      lost_seg = 1'b1;
      return;
    end
    seg_from[seg_fill] = a;
    seg_to[seg_fill]   = b;
    seg_live[seg_fill] = 1'b1;
    seg_fill++;
  endfunction

  // Take the first live segment in table order that touches either end
  function automatic bit extend_path();
    int j;
    for (j = 0; j < SEGS; j++) begin
      if (!seg_live[j])
        continue;
      if (seg_from[j] == path_buf[path_tail]) begin
        path_tail++;
        path_buf[path_tail] = seg_to[j];
      end else if (seg_to[j] == path_buf[path_tail]) begin
        path_tail++;
        path_buf[path_tail] = seg_from[j];
      end else if (seg_from[j] == path_buf[path_head]) begin
        path_head--;
        path_buf[path_head] = seg_to[j];
      end else if (seg_to[j] == path_buf[path_head]) begin
        path_head--;
        path_buf[path_head] = seg_from[j];
      end else begin
        continue;
      end
      seg_live[j] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void assemble_chains();
    int        i;
    int        k;
    bit        flag;
    bit        have_held;
    waypoint_t held;
    flag = lost_seg;
    have_held = 1'b0;
    held = '0;
    i = 0;
    n_assemblies++;
    if (flag)
      n_flagged++;
    while (1) begin
      while (i < SEGS && !seg_live[i])
        i++;
      if (i >= SEGS)
        break;
      seg_live[i] = 1'b0;
      path_head = SEGS;
      path_tail = SEGS + 1;
      path_buf[path_head] = seg_from[i];
      path_buf[path_tail] = seg_to[i];
      while (extend_path())
        ;
      n_chains++;
      for (k = path_head; k <= path_tail; k++) begin
        // hold one back so the final waypoint can be tagged
        if (have_held)
          route_q.push_back(held);
        held.id         = path_buf[k];
        held.chain_last = (k == path_tail);
        held.run_last   = 1'b0;
        held.dropped    = flag;
        have_held = 1'b1;
        n_waypoints++;
      end
    end
    if (have_held) begin
      held.run_last = 1'b1;
      route_q.push_back(held);
    end
    seg_fill  = 0;
    lost_seg  = 1'b0;
    path_head = SEGS;
    path_tail = SEGS;
  endfunction

  task automatic push_add(wp_id_t a, wp_id_t b);
    seg_cmd_t c;
    c.cmd = CMD_ADD;
    c.from_id = a;
    c.to_id = b;
    seg_cmds_q.push_back(c);
  endtask

  task automatic push_assemble();
    seg_cmd_t c;
    c.cmd = CMD_ASSEMBLE;
    c.from_id = wp_id_t'($urandom_range(0, 65535));
    c.to_id = wp_id_t'($urandom_range(0, 65535));
    seg_cmds_q.push_back(c);
  endtask

  // Sender: bursts of transactions with random gaps
  seg_cmd_t on_bus;
  int       burst_left = 1;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (on_bus.cmd == CMD_ADD)
          table_insert(on_bus.from_id, on_bus.to_id);
        else
          assemble_chains();
        items_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (seg_cmds_q.size() > 0) begin
          on_bus = seg_cmds_q.pop_front();
          in_valid   <= 1'b1;
          in_cmd     <= on_bus.cmd;
          in_from_id <= on_bus.from_id;
          in_to_id   <= on_bus.to_id;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches among open, loose, tight and periodic modes
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       rx_phase  = 0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      rx_phase++;
      // hold off once mid-run so the block backs up into its input
      if (!hold_done && items_taken > 150 && route_q.size() > 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     rdy = 1'b1;
          RX_LOOSE:    rdy = ($urandom_range(0, 3) != 0);
          RX_TIGHT:    rdy = ($urandom_range(0, 3) == 0);
          RX_PERIODIC: rdy = (rx_phase % 3 != 0);
          default:     rdy = 1'b1;
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    waypoint_t want;
    if (rst_n && out_valid && out_ready) begin
      if (route_q.size() == 0) begin
        $display("%0t: unexpected waypoint %h (chain_last %b run_last %b dropped %b)",
                 $time, out_waypoint_id, out_chain_last, out_run_last, out_dropped);
        err_cnt++;
      end else begin
        want = route_q.pop_front();
        if (out_waypoint_id !== want.id) begin
          $display("%0t: waypoint_id expected %h actual %h", $time, want.id, out_waypoint_id);
          err_cnt++;
        end
        if (out_chain_last !== want.chain_last) begin
          $display("%0t: chain_last expected %b actual %b", $time, want.chain_last,
                   out_chain_last);
          err_cnt++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.run_last, out_run_last);
          err_cnt++;
        end
        if (out_dropped !== want.dropped) begin
          $display("%0t: dropped expected %b actual %b", $time, want.dropped, out_dropped);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d transactions taken, %0d waypoints outstanding",
               $time, items_taken, total_items, route_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int     k;
    int     pick;
    int     pool_n;
    int     p;
    int     s;
    wp_id_t pool [12];
    wp_id_t a;
    wp_id_t b;

    seg_fill  = 0;
    lost_seg  = 1'b0;
    path_head = SEGS;
    path_tail = SEGS;

    // empty assembly
    push_assemble();
    // fill the table: growth at both ends, reversed pair, self loop, extreme ids
    push_add(16'h0000, 16'hFFFF);
    push_add(16'hFFFF, 16'h1234);
    push_add(16'h5678, 16'h1234);
    push_add(16'hABCD, 16'h0000);
    push_add(16'hABCD, 16'h9999);
    push_add(16'hFFFF, 16'h0000);
    push_add(16'h4242, 16'h4242);
    push_add(16'h8000, 16'h7FFF);
    push_add(16'h0001, 16'hFFFE);
    push_add(16'h7FFF, 16'h5555);
    push_add(16'hAAAA, 16'h8000);
    push_add(16'h3C3C, 16'hC3C3);
    push_add(16'hC3C3, 16'h0001);
    push_add(16'h1111, 16'h2222);
    push_add(16'h2222, 16'h3333);
    push_add(16'h9999, 16'h1111);
    // table full: a new pair is dropped, a duplicate is not
    push_add(16'h0F0F, 16'hF0F0);
    push_add(16'h0000, 16'hFFFF);
    push_assemble();
    // flag must be clear again
    push_assemble();
    push_add(16'h0001, 16'h0002);
    push_assemble();

    while (seg_cmds_q.size() < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        k = 0;
      else if (pick < 70)
        k = $urandom_range(1, 10);
      else if (pick < 90)
        k = $urandom_range(11, 16);
      else
        k = $urandom_range(17, 22);
      // a small id pool makes segments join into longer chains
      pool_n = $urandom_range(2, 12);
      for (p = 0; p < pool_n; p++)
        pool[p] = wp_id_t'($urandom_range(0, 65535));
      for (s = 0; s < k; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          a = wp_id_t'($urandom_range(0, 65535));
          b = wp_id_t'($urandom_range(0, 65535));
        end else begin
          a = pool[$urandom_range(0, pool_n - 1)];
          b = pool[$urandom_range(0, pool_n - 1)];
        end
        push_add(a, b);
      end
      push_assemble();
    end
    total_items = seg_cmds_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < total_items)
      @(posedge clk);
    while (route_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d transactions: %0d assemblies giving %0d chains, %0d waypoints",
             total_items, n_assemblies, n_chains, n_waypoints);
    $display("%0d assemblies carried the dropped flag; receiver held off %0d cycles once",
             n_flagged, HOLD_CYCLES);
    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[segment_chain_assembler.f]
hw/rtl/segchn_pkg.sv
hw/rtl/segment_chain_assembler.sv
bench/segment_chain_assembler_test.sv
